FILE: sv/assert_macros.svh
// Assertion helpers shared by the checker files.
// Each macro expects signals named clk and rst_n in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/tnc_pkg.sv
`default_nettype none

package tnc_pkg;

    // Fixed widths of the transaction fields.
    localparam int OP_W   = 2;
    localparam int TAG_W  = 32;
    localparam int LINE_W = 20;
    localparam int KIND_W = 3;

    // Defaults for the top level parameters.
    localparam int STACK_DEPTH_DEF = 64;
    localparam int TAG_BITS_DEF    = 32;
    localparam int LINE_BITS_DEF   = 20;

    typedef enum logic [OP_W-1:0] {
        OP_OPEN  = 2'd0,
        OP_CLOSE = 2'd1,
        OP_END   = 2'd2
    } tnc_op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_UNMATCHED = 3'd0,
        KIND_MISMATCH  = 3'd1,
        KIND_MISSING   = 3'd2,
        KIND_OVERFLOW  = 3'd3,
        KIND_CLEAN     = 3'd4
    } tnc_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_EMIT,
        ST_DRAIN
    } tnc_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      capture;   // latch the incoming token
        logic      push;      // write the incoming token on top of the stack
        logic      pop;       // read the top entry and decrement the depth
        logic      load_out;  // load the result register
        tnc_kind_t out_kind;  // kind of the result being loaded
    } tnc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        tnc_op_t in_op;      // operation of the token on the input channel
        logic    full;
        logic    empty;
        logic    tag_match;  // top entry read back equals the latched tag
        logic    out_free;   // result register can take a new result this cycle
    } tnc_stat_t;

endpackage

`default_nettype wire

FILE: sv/tnc_tok_if.sv
`default_nettype none

interface tnc_tok_if
    import tnc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [TAG_W-1:0]  tag_id;
    logic [LINE_W-1:0] line_number;

    modport source (output valid, output operation, output tag_id, output line_number,
                    input ready);
    modport sink   (input valid, input operation, input tag_id, input line_number,
                    output ready);
endinterface

`default_nettype wire

FILE: sv/tnc_rpt_if.sv
`default_nettype none

interface tnc_rpt_if
    import tnc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] error_kind;
    logic [LINE_W-1:0] error_line;
    logic [TAG_W-1:0]  found_tag;
    logic [TAG_W-1:0]  expected_tag;
    logic              last_of_run;

    modport source (output valid, output error_kind, output error_line, output found_tag,
                    output expected_tag, output last_of_run, input ready);
    modport sink   (input valid, input error_kind, input error_line, input found_tag,
                    input expected_tag, input last_of_run, output ready);
endinterface

`default_nettype wire

FILE: sv/tag_nesting_checker_top.sv
// Tag nesting checker: takes one markup token per transaction on the tok channel
// (open, close or end of document, with a tag identifier and a line number) and
// reports nesting errors as transactions on the rpt channel.
// An open token is taken every cycle while the controller is idle: it writes the stack.
// A close token holds the input while it is handled: the top entry is read from the
// stack memory, whose read data is registered, and then compared in the compare state.
// A token that reports a result (mismatch, unmatched close, overflow, clean end)
// moves the controller to the compare or emit state, which loads the result into
// the output register once it is free; rpt.valid is driven by that register.
// An end of document with N open entries gives N missing-close results, one stack
// read per cycle while the output register is free; the last carries last_of_run.
// Results leave through a single output register, so the next token is accepted
// while an earlier result still waits on the rpt channel.
// When the receiver holds rpt.ready low, the result stays put and the controller
// waits in any state that must load a new result; open tokens keep being taken.
// Reset empties the stack and the output register; the stack memory itself is not
// cleared, since only entries below the current depth are ever read.
`default_nettype none

module tag_nesting_checker_top
    import tnc_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int TAG_BITS    = TAG_BITS_DEF,
    parameter int LINE_BITS   = LINE_BITS_DEF
)
(
    input wire logic   clk,
    input wire logic   rst_n,
    tnc_tok_if.sink    tok,
    tnc_rpt_if.source  rpt
);

    // Command and status groups between the controller and the datapath.
    tnc_cmd_t  cmd;
    tnc_stat_t stat;
    logic      in_ready;

    assign tok.ready = in_ready;

    // The controller sequences each token: push, read and compare, or drain.
    tnc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (tok.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the stack, the depth counter and the result register.
    tnc_dp #(
        .STACK_DEPTH (STACK_DEPTH),
        .TAG_BITS    (TAG_BITS),
        .LINE_BITS   (LINE_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_operation     (tok.operation),
        .in_tag_id        (tok.tag_id),
        .in_line_number   (tok.line_number),
        .out_valid        (rpt.valid),
        .out_ready        (rpt.ready),
        .out_error_kind   (rpt.error_kind),
        .out_error_line   (rpt.error_line),
        .out_found_tag    (rpt.found_tag),
        .out_expected_tag (rpt.expected_tag),
        .out_last_of_run  (rpt.last_of_run),
        .cmd              (cmd),
        .stat             (stat)
    );

endmodule

`default_nettype wire

FILE: sv/tnc_ctrl.sv
`default_nettype none

module tnc_ctrl
    import tnc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire tnc_stat_t stat,
    output tnc_cmd_t       cmd
);

    tnc_state_t state_reg, state_next;
    tnc_kind_t  kind_reg, kind_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            kind_reg  <= KIND_CLEAN;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        in_ready     = 1'b0;
        cmd.capture  = 1'b0;
        cmd.push     = 1'b0;
        cmd.pop      = 1'b0;
        cmd.load_out = 1'b0;
        cmd.out_kind = kind_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    case (stat.in_op)
                        OP_OPEN:
                        begin
                            if (stat.full)
                            begin
                                kind_next  = KIND_OVERFLOW;
                                state_next = ST_EMIT;
                            end
                            else
                            begin
                                cmd.push = 1'b1;
                            end
                        end
                        OP_CLOSE:
                        begin
                            if (stat.empty)
                            begin
                                kind_next  = KIND_UNMATCHED;
                                state_next = ST_EMIT;
                            end
                            else
                            begin
                                cmd.pop    = 1'b1;
                                state_next = ST_CMP;
                            end
                        end
                        OP_END:
                        begin
                            if (stat.empty)
                            begin
                                kind_next  = KIND_CLEAN;
                                state_next = ST_EMIT;
                            end
                            else
                            begin
                                cmd.pop    = 1'b1;
                                state_next = ST_DRAIN;
                            end
                        end
                        default:
                        begin
                            // The unused operation code is dropped without touching the stack or the result.
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CMP:
            begin
                cmd.out_kind = KIND_MISMATCH;
                if (stat.tag_match)
                begin
                    state_next = ST_IDLE;
                end
                else if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_DRAIN:
            begin
                cmd.out_kind = KIND_MISSING;
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    if (stat.empty)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.pop = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/tnc_dp.sv
`default_nettype none

module tnc_dp
    import tnc_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int TAG_BITS    = TAG_BITS_DEF,
    parameter int LINE_BITS   = LINE_BITS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [OP_W-1:0]   in_operation,
    input  wire logic [TAG_W-1:0]  in_tag_id,
    input  wire logic [LINE_W-1:0] in_line_number,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [KIND_W-1:0]      out_error_kind,
    output logic [LINE_W-1:0]      out_error_line,
    output logic [TAG_W-1:0]       out_found_tag,
    output logic [TAG_W-1:0]       out_expected_tag,
    output logic                   out_last_of_run,
    input  wire tnc_cmd_t          cmd,
    output tnc_stat_t              stat
);

    localparam int IDX_W   = $clog2(STACK_DEPTH);
    localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
    localparam int ENTRY_W = TAG_BITS + LINE_BITS;

    logic [ENTRY_W-1:0]   mem [STACK_DEPTH];
    logic [ENTRY_W-1:0]   rd_data_reg;
    logic [CNT_W-1:0]     depth_reg, depth_next;
    logic [CNT_W-1:0]     depth_dec;
    logic [TAG_BITS-1:0]  tag_in;
    logic [LINE_BITS-1:0] line_in;
    logic [TAG_BITS-1:0]  item_tag_reg;
    logic [LINE_BITS-1:0] item_line_reg;
    logic [TAG_BITS-1:0]  rd_tag;
    logic [LINE_BITS-1:0] rd_line;

    logic                 out_valid_reg;
    tnc_kind_t            out_kind_reg, out_kind_next;
    logic [LINE_W-1:0]    out_line_reg, out_line_next;
    logic [TAG_W-1:0]     out_found_reg, out_found_next;
    logic [TAG_W-1:0]     out_exp_reg, out_exp_next;
    logic                 out_last_reg, out_last_next;

    assign tag_in    = TAG_BITS'(in_tag_id);
    assign line_in   = LINE_BITS'(in_line_number);
    assign depth_dec = depth_reg - CNT_W'(1);
    assign rd_tag    = rd_data_reg[ENTRY_W-1:LINE_BITS];
    assign rd_line   = rd_data_reg[LINE_BITS-1:0];

    always_comb
    begin
        depth_next = depth_reg;
        if (cmd.push)
        begin
            depth_next = depth_reg + CNT_W'(1);
        end
        else if (cmd.pop)
        begin
            depth_next = depth_dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
        end
        else
        begin
            depth_reg <= depth_next;
        end
    end

    // Stack storage: one write port for pushes, one registered read port for pops.
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[depth_reg[IDX_W-1:0]] <= {tag_in, line_in};
        end
        if (cmd.pop)
        begin
            rd_data_reg <= mem[depth_dec[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_tag_reg  <= tag_in;
            item_line_reg <= line_in;
        end
    end

    always_comb
    begin
        out_kind_next  = cmd.out_kind;
        out_line_next  = LINE_W'(item_line_reg);
        out_found_next = TAG_W'(item_tag_reg);
        out_exp_next   = '0;
        out_last_next  = 1'b1;
        unique case (cmd.out_kind)
            KIND_MISSING:
            begin
                out_line_next  = LINE_W'(rd_line);
                out_found_next = TAG_W'(rd_tag);
                out_last_next  = (depth_reg == '0);
            end
            KIND_MISMATCH:
            begin
                out_exp_next = TAG_W'(rd_tag);
            end
            KIND_CLEAN:
            begin
                out_found_next = '0;
            end
            default:
            begin
                out_found_next = TAG_W'(item_tag_reg);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_kind_reg  <= out_kind_next;
            out_line_reg  <= out_line_next;
            out_found_reg <= out_found_next;
            out_exp_reg   <= out_exp_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_error_kind   = out_kind_reg;
    assign out_error_line   = out_line_reg;
    assign out_found_tag    = out_found_reg;
    assign out_expected_tag = out_exp_reg;
    assign out_last_of_run  = out_last_reg;

    assign stat.in_op     = tnc_op_t'(in_operation);
    assign stat.full      = (depth_reg == CNT_W'(STACK_DEPTH));
    assign stat.empty     = (depth_reg == '0);
    assign stat.tag_match = (rd_tag == item_tag_reg);
    assign stat.out_free  = !out_valid_reg || out_ready;

endmodule

`default_nettype wire

FILE: sv/tnc_checker.sv
`default_nettype none
`include "assert_macros.svh"

module tnc_checker
    import tnc_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              rpt_valid,
    input wire logic              rpt_ready,
    input wire logic [KIND_W-1:0] error_kind,
    input wire logic [LINE_W-1:0] error_line,
    input wire logic [TAG_W-1:0]  found_tag,
    input wire logic [TAG_W-1:0]  expected_tag,
    input wire logic              last_of_run
);

    // A stalled result keeps its contents.
    `ASSERT_NEXT(a_rpt_hold, rpt_valid && !rpt_ready, rpt_valid && $stable(error_kind) && $stable(error_line) && $stable(found_tag) && $stable(expected_tag) && $stable(last_of_run), "stalled result changed")

    // Only a mismatch carries an expected tag.
    `ASSERT_SAME(a_exp_zero, rpt_valid && (error_kind != KIND_MISMATCH), expected_tag == '0, "expected tag set outside a mismatch")

    // Every kind but a missing close is the only result of its token.
    `ASSERT_SAME(a_single_last, rpt_valid && (error_kind != KIND_MISSING), last_of_run, "single result not marked last")

    // A clean end names no tag.
    `ASSERT_SAME(a_clean_tag, rpt_valid && (error_kind == KIND_CLEAN), found_tag == '0, "clean end with a tag")

endmodule

bind tag_nesting_checker_top tnc_checker u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .rpt_valid    (rpt.valid),
    .rpt_ready    (rpt.ready),
    .error_kind   (rpt.error_kind),
    .error_line   (rpt.error_line),
    .found_tag    (rpt.found_tag),
    .expected_tag (rpt.expected_tag),
    .last_of_run  (rpt.last_of_run)
);

`default_nettype wire
